### hw/rtl/tsps_pkg.sv
// Package for the timed servo pulse schedule: field widths, status and phase
// codes, register indexes and the packed segment layout. No dependencies.
package tsps_pkg;

  localparam int TICK_W     = 20;
  localparam int DUR_W      = 16;
  localparam int OFFUS_W    = 12;
  localparam int STEP_W     = 16;
  localparam int PULSE_W    = 12;
  localparam int OFFSET_W   = 34;
  localparam int NUM_SERVOS = 4;
  localparam int NUM_SEGS   = 3;
  localparam int DEF_MAX_SEGMENTS = 3;

  localparam int APB_DW = 64;
  localparam int APB_AW = 6;

  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_SUCCESS = 2'd1;
  localparam logic [1:0] ST_FAILURE = 2'd2;

  localparam logic [1:0] PH_WAIT   = 2'd0;
  localparam logic [1:0] PH_ACTIVE = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // hold segment: pulses move but drive is flagged off
  localparam logic [1:0] HOLD_SEG = 2'd1;

  localparam logic [2:0] REG_SEG0      = 3'd0;
  localparam logic [2:0] REG_SEG1      = 3'd1;
  localparam logic [2:0] REG_SEG2      = 3'd2;
  localparam logic [2:0] REG_BASE      = 3'd3;
  localparam logic [2:0] REG_DIR       = 3'd4;
  localparam logic [2:0] REG_SEG_USE   = 3'd5;
  localparam logic [2:0] REG_PULSE_MIN = 3'd6;
  localparam logic [2:0] REG_PULSE_MAX = 3'd7;

  localparam logic [NUM_SERVOS*PULSE_W-1:0] BASE_RESET = 48'd103104387073500;
  localparam logic [PULSE_W-1:0] FLOOR_RESET = 12'd500;
  localparam logic [PULSE_W-1:0] CEIL_RESET  = 12'd2500;

  typedef struct packed {
    logic signed [STEP_W-1:0]  step;
    logic signed [OFFUS_W-1:0] off_us;
    logic [DUR_W-1:0]          dur;
    logic [TICK_W-1:0]         start;
  } seg_t;

endpackage

### hw/rtl/tsps_if.sv
// Stream interfaces for the servo pulse schedule: tick request in, pulse
// result out. Depends on tsps_pkg.
interface tsps_in_if import tsps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] tick_now;
  logic              run_enable;

  modport source (output valid, tick_now, run_enable, input ready);
  modport sink   (input valid, tick_now, run_enable, output ready);
endinterface

interface tsps_out_if import tsps_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [PULSE_W-1:0]         pulse_servo0;
  logic [PULSE_W-1:0]         pulse_servo1;
  logic [PULSE_W-1:0]         pulse_servo2;
  logic [PULSE_W-1:0]         pulse_servo3;
  logic [1:0]                 phase;
  logic [1:0]                 segment_hit;
  logic signed [OFFSET_W-1:0] offset_q8;
  logic                       drive_active;
  logic [1:0]                 status;

  modport source (output valid, pulse_servo0, pulse_servo1, pulse_servo2, pulse_servo3,
                  phase, segment_hit, offset_q8, drive_active, status, input ready);
  modport sink   (input valid, pulse_servo0, pulse_servo1, pulse_servo2, pulse_servo3,
                  phase, segment_hit, offset_q8, drive_active, status, output ready);
endinterface

### hw/rtl/tsps_servo.sv
// One servo lane: applies the signed Q.8 offset to a base pulse, floors to
// whole microseconds and clamps. Depends on tsps_pkg.
module tsps_servo import tsps_pkg::*; (
  input  logic [PULSE_W-1:0]         base,
  input  logic                       sub,
  input  logic                       use_offset,
  input  logic signed [OFFSET_W-1:0] offset,
  input  logic [PULSE_W-1:0]         pulse_min,
  input  logic [PULSE_W-1:0]         pulse_max,
  output logic [PULSE_W-1:0]         pulse
);

  localparam int SUM_W = OFFSET_W + 2;
  localparam int V_W   = SUM_W - 8;

  logic signed [SUM_W-1:0] base_q;
  logic signed [SUM_W-1:0] off_x;
  logic signed [SUM_W-1:0] sum;
  logic signed [V_W-1:0]   v;
  logic signed [V_W-1:0]   lo;
  logic signed [V_W-1:0]   hi;

  always_comb begin
    base_q = $signed(SUM_W'({base, 8'd0}));
    off_x  = SUM_W'(offset);
    sum    = sub ? (base_q - off_x) : (base_q + off_x);
    // dropping the fraction of a two's complement value floors it
    v      = sum[SUM_W-1:8];
    lo     = $signed(V_W'(pulse_min));
    hi     = $signed(V_W'(pulse_max));
    if (!use_offset) begin
      pulse = base;
    end else if (v < lo) begin
      pulse = pulse_min;
    end else if (v > hi) begin
      pulse = pulse_max;
    end else begin
      pulse = v[PULSE_W-1:0];
    end
  end

endmodule

### hw/rtl/timed_servo_pulse_schedule.sv
// Channel   Dir  Payload                                        Handshake
// in_ch     in   tick_now[19:0], run_enable                     valid/ready
// out_ch    out  pulse_servo0..3, phase, segment_hit,           valid/ready
//                offset_q8[33:0], drive_active, status
// apb       in   psel/penable/pwrite/paddr[5:3]/pwdata[63:0]    pready tied high
//
// One request per cycle sustained while the output accepts; pipeline stages are
// window compare, step multiply, offset add, servo add/clamp into the output register.
// Each stage holds its own valid bit; a stage refills whenever the one after
// it is empty or moving, so a stalled output keeps upstream stages filling.
// Synchronous active-low reset clears valid bits and presets configuration registers.
// Top level of the servo pulse schedule. Depends on tsps_pkg, tsps_if and
// tsps_servo.
module timed_servo_pulse_schedule import tsps_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic              clk,
  input  logic              rst_n,
  tsps_in_if.sink           in_ch,
  tsps_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [1:0] MaxSegCnt = 2'(MAX_SEGMENTS);

  typedef struct packed {
    logic       hit;
    logic [1:0] seg;
    logic [1:0] status;
    logic [1:0] phase;
  } meta_t;

  // ---------------- configuration ----------------
  seg_t                            seg_r [NUM_SEGS];
  logic [NUM_SERVOS*PULSE_W-1:0]   base_r;
  logic [NUM_SERVOS-1:0]           dir_r;
  logic [1:0]                      seg_use_r;
  logic [PULSE_W-1:0]              pmin_r;
  logic [PULSE_W-1:0]              pmax_r;
  logic                            wr_en;
  logic [2:0]                      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEGS; i++) seg_r[i] <= '0;
      base_r    <= BASE_RESET;
      dir_r     <= 4'd1;
      seg_use_r <= 2'd3;
      pmin_r    <= FLOOR_RESET;
      pmax_r    <= CEIL_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SEG0:      seg_r[0]  <= seg_t'(pwdata);
        REG_SEG1:      seg_r[1]  <= seg_t'(pwdata);
        REG_SEG2:      seg_r[2]  <= seg_t'(pwdata);
        REG_BASE:      base_r    <= pwdata[NUM_SERVOS*PULSE_W-1:0];
        REG_DIR:       dir_r     <= pwdata[NUM_SERVOS-1:0];
        REG_SEG_USE:   seg_use_r <= pwdata[1:0];
        REG_PULSE_MIN: pmin_r    <= pwdata[PULSE_W-1:0];
        REG_PULSE_MAX: pmax_r    <= pwdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SEG0:      prdata = APB_DW'(seg_r[0]);
      REG_SEG1:      prdata = APB_DW'(seg_r[1]);
      REG_SEG2:      prdata = APB_DW'(seg_r[2]);
      REG_BASE:      prdata = APB_DW'(base_r);
      REG_DIR:       prdata = APB_DW'(dir_r);
      REG_SEG_USE:   prdata = APB_DW'(seg_use_r);
      REG_PULSE_MIN: prdata = APB_DW'(pmin_r);
      REG_PULSE_MAX: prdata = APB_DW'(pmax_r);
      default:       prdata = '0;
    endcase
  end

  // ---------------- pipeline flow control ----------------
  logic v1_r, v2_r, v3_r, ov_r;
  logic rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out     = !ov_r || out_ch.ready;
  assign rdy3        = !v3_r || rdy_out;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r <= in_ch.valid;
      if (rdy2)    v2_r <= v1_r;
      if (rdy3)    v3_r <= v2_r;
      if (rdy_out) ov_r <= v3_r;
    end
  end

  // ---------------- stage 1: window search ----------------
  logic [1:0]               eff_cnt;
  logic                     any_seg;
  logic [TICK_W:0]          last_end;
  logic                     hit;
  logic [1:0]               hit_idx;
  logic [DUR_W-1:0]         elapsed;
  logic signed [OFFUS_W-1:0] hit_off;
  logic signed [STEP_W-1:0] hit_step;
  logic [TICK_W:0]          seg_end;
  logic                     in_use;
  meta_t                    meta1;

  always_comb begin
    eff_cnt  = (seg_use_r > MaxSegCnt) ? MaxSegCnt : seg_use_r;
    any_seg  = 1'b0;
    last_end = '0;
    hit      = 1'b0;
    hit_idx  = 2'd0;
    elapsed  = '0;
    hit_off  = '0;
    hit_step = '0;
    seg_end  = '0;
    in_use   = 1'b0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      in_use  = (2'(i) < eff_cnt) && (seg_r[i].dur != '0);
      seg_end = {1'b0, seg_r[i].start} + (TICK_W+1)'(seg_r[i].dur);
      if (in_use) begin
        any_seg = 1'b1;
        if (seg_end > last_end) last_end = seg_end;
        if (!hit && in_ch.tick_now >= seg_r[i].start && {1'b0, in_ch.tick_now} < seg_end) begin
          hit      = 1'b1;
          hit_idx  = 2'(i);
          elapsed  = DUR_W'(in_ch.tick_now - seg_r[i].start);
          hit_off  = seg_r[i].off_us;
          hit_step = seg_r[i].step;
        end
      end
    end

    meta1 = '{hit: 1'b0, seg: 2'd0, status: ST_RUNNING, phase: PH_WAIT};
    if (!in_ch.run_enable || eff_cnt == 2'd0) begin
      meta1.status = ST_FAILURE;
    end else if (hit) begin
      meta1.hit   = 1'b1;
      meta1.seg   = hit_idx;
      meta1.phase = (hit_idx != HOLD_SEG) ? PH_ACTIVE : PH_WAIT;
    end else if (any_seg && {1'b0, in_ch.tick_now} >= last_end) begin
      meta1.status = ST_SUCCESS;
      meta1.phase  = PH_DONE;
    end
  end

  meta_t                     meta1_r, meta2_r, meta3_r;
  logic [DUR_W-1:0]          elapsed_r;
  logic signed [OFFUS_W-1:0] off1_r, off2_r;
  logic signed [STEP_W-1:0]  step_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      meta1_r   <= meta1;
      elapsed_r <= elapsed;
      off1_r    <= hit_off;
      step_r    <= hit_step;
    end
  end

  // ---------------- stage 2: elapsed * step ----------------
  localparam int PROD_W = DUR_W + STEP_W + 1;
  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      meta2_r <= meta1_r;
      off2_r  <= off1_r;
      prod_r  <= PROD_W'($signed({1'b0, elapsed_r}) * step_r);
    end
  end

  // ---------------- stage 3: offset sum ----------------
  logic signed [OFFSET_W-1:0] off_base;
  logic signed [OFFSET_W-1:0] offset_r;

  assign off_base = $signed({(OFFSET_W-8)'(off2_r), 8'd0});

  always_ff @(posedge clk) begin
    if (rdy3) begin
      meta3_r  <= meta2_r;
      offset_r <= off_base + OFFSET_W'(prod_r);
    end
  end

  // ---------------- stage 4: servo lanes into output register ----------------
  logic [PULSE_W-1:0] pulse [NUM_SERVOS];

  for (genvar s = 0; s < NUM_SERVOS; s++) begin : g_servo
    tsps_servo u_servo (
      .base       (base_r[s*PULSE_W +: PULSE_W]),
      .sub        (dir_r[s]),
      .use_offset (meta3_r.hit),
      .offset     (offset_r),
      .pulse_min  (pmin_r),
      .pulse_max  (pmax_r),
      .pulse      (pulse[s])
    );
  end

  logic [PULSE_W-1:0]         p0_r, p1_r, p2_r, p3_r;
  logic [1:0]                 phase_r, seg_hit_r, status_r;
  logic signed [OFFSET_W-1:0] offset_out_r;
  logic                       drive_r;

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      p0_r         <= pulse[0];
      p1_r         <= pulse[1];
      p2_r         <= pulse[2];
      p3_r         <= pulse[3];
      phase_r      <= meta3_r.phase;
      status_r     <= meta3_r.status;
      seg_hit_r    <= meta3_r.hit ? meta3_r.seg : 2'd0;
      offset_out_r <= meta3_r.hit ? offset_r : '0;
      drive_r      <= meta3_r.hit && (meta3_r.seg != HOLD_SEG);
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.pulse_servo0 = p0_r;
  assign out_ch.pulse_servo1 = p1_r;
  assign out_ch.pulse_servo2 = p2_r;
  assign out_ch.pulse_servo3 = p3_r;
  assign out_ch.phase        = phase_r;
  assign out_ch.segment_hit  = seg_hit_r;
  assign out_ch.offset_q8    = offset_out_r;
  assign out_ch.drive_active = drive_r;
  assign out_ch.status       = status_r;

  // ---------------- assertions ----------------
  a_stall_keeps_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy_out) |=> v3_r)
    else $error("stage 3 request lost under output stall");

  a_success_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ((status_r == ST_SUCCESS) == (phase_r == PH_DONE)))
    else $error("success status and done phase disagree");

  a_drive_active: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && drive_r) |-> (phase_r == PH_ACTIVE && seg_hit_r != HOLD_SEG))
    else $error("drive_active outside an active segment");

  a_failure_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && status_r == ST_FAILURE) |-> (offset_out_r == '0 && !drive_r && phase_r == PH_WAIT))
    else $error("failure result carries segment data");

endmodule

### tb/tsps_pulse_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the servo pulse schedule: mirrors APB register writes, predicts
// the pulse result of every accepted tick request and compares it with the output.
// Depends on tsps_pkg and the stream interfaces in tsps_if.
module tsps_pulse_checker import tsps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tsps_in_if                in_ch,
  tsps_out_if               out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                mismatch_count,
  output int                pulses_awaited
);

  typedef struct packed {
    logic [NUM_SERVOS-1:0][PULSE_W-1:0] pulse;
    logic [1:0]                         phase;
    logic [1:0]                         segment_hit;
    logic signed [OFFSET_W-1:0]         offset_q8;
    logic                               drive_active;
    logic [1:0]                         status;
  } pulse_result_t;

  seg_t                               seg_cfg [NUM_SEGS];
  logic [NUM_SERVOS-1:0][PULSE_W-1:0] base_pulse;
  logic [NUM_SERVOS-1:0]              dir_mask;
  logic [1:0]                         seg_use;
  logic [PULSE_W-1:0]                 pulse_floor;
  logic [PULSE_W-1:0]                 pulse_ceil;

  pulse_result_t awaited_q [$];
  int            mismatches;

  function automatic pulse_result_t predict_pulses(logic [TICK_W-1:0] tick, logic en);
    pulse_result_t   r;
    int              n_seg;
    logic [TICK_W:0] win_end;
    logic [TICK_W:0] last_end;
    logic            hit;
    logic            any_live;
    longint          ofs;
    longint          q;
    r = '0;
    r.pulse = base_pulse;
    n_seg = (seg_use > DEF_MAX_SEGMENTS) ? DEF_MAX_SEGMENTS : seg_use;
    if (!en || n_seg == 0) begin
      r.status = ST_FAILURE;
      return r;
    end
    hit = 1'b0;
    any_live = 1'b0;
    last_end = '0;
    for (int i = 0; i < n_seg; i++) begin
      if (!hit && seg_cfg[i].dur != '0) begin
        // end tick carries one extra bit so a late window never wraps
        win_end = {1'b0, seg_cfg[i].start} + seg_cfg[i].dur;
        any_live = 1'b1;
        if (win_end > last_end) last_end = win_end;
        if (tick >= seg_cfg[i].start && {1'b0, tick} < win_end) begin
          hit = 1'b1;
          ofs = longint'(seg_cfg[i].off_us) * 256
              + longint'(tick - seg_cfg[i].start) * longint'(seg_cfg[i].step);
          for (int s = 0; s < NUM_SERVOS; s++) begin
            q = longint'({base_pulse[s], 8'h00});
            q = dir_mask[s] ? q - ofs : q + ofs;
            q = q >>> 8;
            // floor wins when floor and ceiling cross
            if (q < longint'(pulse_floor)) q = longint'(pulse_floor);
            else if (q > longint'(pulse_ceil)) q = longint'(pulse_ceil);
            r.pulse[s] = q[PULSE_W-1:0];
          end
          r.phase = (i == HOLD_SEG) ? PH_WAIT : PH_ACTIVE;
          r.segment_hit = i[1:0];
          r.offset_q8 = ofs[OFFSET_W-1:0];
          r.drive_active = (i != HOLD_SEG);
          r.status = ST_RUNNING;
        end
      end
    end
    if (!hit && any_live && {1'b0, tick} >= last_end) begin
      r.phase = PH_DONE;
      r.status = ST_SUCCESS;
    end
    return r;
  endfunction

  function automatic string show(pulse_result_t r);
    return $sformatf("pulses %0d/%0d/%0d/%0d phase %0d seg %0d offset %0d drive %0b status %0d",
                     r.pulse[0], r.pulse[1], r.pulse[2], r.pulse[3], r.phase,
                     r.segment_hit, r.offset_q8, r.drive_active, r.status);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      seg_cfg <= '{default: '0};
      base_pulse <= BASE_RESET;
      dir_mask <= 4'b0001;
      seg_use <= 2'd3;
      pulse_floor <= FLOOR_RESET;
      pulse_ceil <= CEIL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[APB_AW-1:3])
        REG_SEG0:      seg_cfg[0] <= pwdata;
        REG_SEG1:      seg_cfg[1] <= pwdata;
        REG_SEG2:      seg_cfg[2] <= pwdata;
        REG_BASE:      base_pulse <= pwdata[NUM_SERVOS*PULSE_W-1:0];
        REG_DIR:       dir_mask <= pwdata[NUM_SERVOS-1:0];
        REG_SEG_USE:   seg_use <= pwdata[1:0];
        REG_PULSE_MIN: pulse_floor <= pwdata[PULSE_W-1:0];
        REG_PULSE_MAX: pulse_ceil <= pwdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    pulse_result_t seen;
    pulse_result_t want;
    if (!rst_n) begin
      awaited_q.delete();
      mismatches = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        awaited_q.push_back(predict_pulses(in_ch.tick_now, in_ch.run_enable));
      if (out_ch.valid && out_ch.ready) begin
        seen.pulse[0] = out_ch.pulse_servo0;
        seen.pulse[1] = out_ch.pulse_servo1;
        seen.pulse[2] = out_ch.pulse_servo2;
        seen.pulse[3] = out_ch.pulse_servo3;
        seen.phase = out_ch.phase;
        seen.segment_hit = out_ch.segment_hit;
        seen.offset_q8 = out_ch.offset_q8;
        seen.drive_active = out_ch.drive_active;
        seen.status = out_ch.status;
        if (awaited_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no request outstanding: %s", $time, show(seen));
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          if (seen !== want) begin
            if (mismatches < 10) begin
              $display("%0t: pulse result mismatch", $time);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(seen));
            end
            mismatches++;
          end
        end
      end
    end
    mismatch_count <= mismatches;
    pulses_awaited <= awaited_q.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the servo pulse schedule: clock, reset, APB register setup,
// tick requests with random gaps and stalls, watchdog and verdict.
// Depends on tsps_pkg, tsps_if, tsps_pulse_checker and the RTL top.
module tb;
  import tsps_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_REQS  = 53;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                mismatch_count;
  int                pulses_awaited;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                quiet_cycles = 0;
  seg_t              seg_mirror [NUM_SEGS];
  int                idle_sched [4] = '{0, 59, 0, 11};
  int                stall_sched [4] = '{0, 0, 59, 11};

  tsps_in_if  in_ch ();
  tsps_out_if out_ch ();

  timed_servo_pulse_schedule u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tsps_pulse_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .pulses_awaited (pulses_awaited)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ready is sampled at the falling edge so the request edge is race free
  task automatic send_tick(logic [TICK_W-1:0] tick, logic en);
    logic acc;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick_now <= tick;
    in_ch.run_enable <= en;
    do begin
      @(negedge clk);
      acc = in_ch.ready;
      @(posedge clk);
    end while (!acc);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [APB_DW-1:0] val);
    logic rdy;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // hold off requests until every result is back, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pulses_awaited != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_settings(seg_t s0, seg_t s1, seg_t s2,
                               logic [NUM_SERVOS*PULSE_W-1:0] base, logic [3:0] dir,
                               logic [1:0] seg_count, logic [PULSE_W-1:0] floor_us,
                               logic [PULSE_W-1:0] ceil_us);
    drain();
    seg_mirror[0] = s0;
    seg_mirror[1] = s1;
    seg_mirror[2] = s2;
    reg_write(REG_SEG0, s0);
    reg_write(REG_SEG1, s1);
    reg_write(REG_SEG2, s2);
    reg_write(REG_BASE, APB_DW'(base));
    reg_write(REG_DIR, APB_DW'(dir));
    reg_write(REG_SEG_USE, APB_DW'(seg_count));
    reg_write(REG_PULSE_MIN, APB_DW'(floor_us));
    reg_write(REG_PULSE_MAX, APB_DW'(ceil_us));
  endtask

  function automatic seg_t make_seg(int unsigned start, int unsigned dur, int off_us, int step);
    seg_t s;
    s.start = start[TICK_W-1:0];
    s.dur = dur[DUR_W-1:0];
    s.off_us = off_us[OFFUS_W-1:0];
    s.step = step[STEP_W-1:0];
    return s;
  endfunction

  function automatic seg_t rand_seg();
    int unsigned start;
    int unsigned dur;
    int          step;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 8) start = $urandom_range(0, 3000);
    else if (pick == 8) start = $urandom;
    else start = 32'hFFFFF - $urandom_range(0, 500);
    pick = $urandom_range(0, 9);
    if (pick == 0) dur = 0;
    else if (pick == 1) dur = $urandom;
    else dur = $urandom_range(1, 400);
    if ($urandom_range(0, 1) == 0) step = $urandom;
    else step = int'($urandom_range(0, 1200)) - 600;
    return make_seg(start, dur, $urandom, step);
  endfunction

  function automatic logic [PULSE_W-1:0] rand_pulse();
    logic [31:0] v;
    if ($urandom_range(0, 9) < 7) v = $urandom_range(900, 2100);
    else v = $urandom;
    return v[PULSE_W-1:0];
  endfunction

  task automatic random_settings();
    logic [PULSE_W-1:0] lo;
    logic [PULSE_W-1:0] hi;
    logic [1:0]         seg_count;
    int                 pick;
    pick = $urandom_range(0, 19);
    if (pick < 15) begin
      lo = PULSE_W'($urandom_range(0, 1200));
      hi = PULSE_W'($urandom_range(1800, 4095));
    end else if (pick < 18) begin
      lo = PULSE_W'($urandom_range(1500, 4095));
      hi = PULSE_W'($urandom_range(0, 1499));
    end else begin
      lo = '0;
      hi = '1;
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) seg_count = 2'd0;
    else if (pick < 3) seg_count = 2'd1;
    else if (pick < 5) seg_count = 2'd2;
    else seg_count = 2'd3;
    load_settings(rand_seg(), rand_seg(), rand_seg(),
                  {rand_pulse(), rand_pulse(), rand_pulse(), rand_pulse()},
                  4'($urandom), seg_count, lo, hi);
  endtask

  // mostly ticks inside or just around a segment window, some anywhere, some at the extremes
  function automatic logic [TICK_W-1:0] pick_tick();
    int unsigned k;
    int unsigned t;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      k = $urandom_range(0, NUM_SEGS - 1);
      t = seg_mirror[k].start + $urandom_range(0, seg_mirror[k].dur + 8) - 4;
    end else if (pick < 92) begin
      t = $urandom;
    end else begin
      t = (pick < 96) ? 32'h0 : 32'hFFFFF;
    end
    return t[TICK_W-1:0];
  endfunction

  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.tick_now <= '0;
    in_ch.run_enable <= 1'b0;
    seg_mirror = '{default: '0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: every segment empty
    send_tick(20'd0, 1'b1);
    send_tick(20'hFFFFF, 1'b1);
    send_tick(20'd7, 1'b0);

    // overlapping first two windows, hold segment, late window ending at tick FFFFF
    load_settings(make_seg(100, 50, 10, 256), make_seg(140, 30, -5, -3),
                  make_seg(20'hF0000, 16'hFFFF, -2048, -32768),
                  {12'd0, 12'hFFF, 12'd1500, 12'd1000}, 4'b1010, 2'd3, 12'd0, 12'hFFF);
    send_tick(20'd0, 1'b1);
    send_tick(20'd99, 1'b1);
    send_tick(20'd100, 1'b1);
    send_tick(20'd149, 1'b1);
    send_tick(20'd150, 1'b1);
    send_tick(20'd169, 1'b1);
    send_tick(20'd170, 1'b1);
    send_tick(20'hF0000, 1'b1);
    send_tick(20'hFFFFF, 1'b1);
    send_tick(20'd150, 1'b0);

    // no segment in use, floor above ceiling
    load_settings(make_seg(10, 5, 300, -700), make_seg(30, 0, 0, 0), make_seg(0, 0, 0, 0),
                  {12'd1200, 12'd1800, 12'd1500, 12'd1500}, 4'b0101, 2'd0,
                  12'd2000, 12'd1000);
    send_tick(20'd12, 1'b1);
    drain();
    reg_write(REG_SEG_USE, APB_DW'(2'd2));
    send_tick(20'd9, 1'b1);
    send_tick(20'd10, 1'b1);
    send_tick(20'd14, 1'b1);
    send_tick(20'd15, 1'b1);
    send_tick(20'hFFFFF, 1'b1);

    // every window in use has zero duration
    drain();
    seg_mirror[0] = make_seg(10, 0, 300, -700);
    reg_write(REG_SEG0, seg_mirror[0]);
    send_tick(20'd10, 1'b1);
    send_tick(20'hFFFFF, 1'b1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES - 1)
        load_settings(make_seg(0, 300, 2047, 32767), make_seg(200, 400, -2048, -32768),
                      make_seg(20'hFFFFF, 16'hFFFF, -1, 1),
                      {12'hFFF, 12'h000, 12'hFFF, 12'h000}, 4'b1111, 2'd3, 12'd0, 12'hFFF);
      else
        random_settings();
      idle_pct = idle_sched[p % 4];
      stall_pct = stall_sched[p % 4];
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n == PHASE_REQS / 2 && p % 3 == 1) drain();
        send_tick(pick_tick(), $urandom_range(0, 11) != 0);
      end
    end

    stall_pct = 0;
    drain();
    if (mismatch_count == 0 && pulses_awaited == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
